@@ sv/sha256_stream_hasher_assert.svh @@
// Assertion macros used by the checker file.
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ sv/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg
// Constants, types and round functions shared by the SHA-256 hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LENGTH_OFFSET = 6'd56;
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Byte source codes used when the controller writes the block buffer.
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN = 2'd3
  } byte_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic buf_write;
    byte_src_t buf_src;
    logic [5:0] buf_addr;
    logic count_inc;
    logic count_clear;
    logic comp_init;
    logic round_en;
    logic [5:0] round_idx;
    logic hash_update;
    logic hash_reinit;
    logic [2:0] len_sel;
    logic [2:0] out_sel;
  } dp_cmd_t;

  // Status from the datapath: the schedule word read back is not needed,
  // and the controller does not use the byte count that it carries.
  typedef struct packed {
    logic [63:0] byte_count;
  } dp_stat_t;

  function automatic logic [31:0] initial_hash(input logic [2:0] i);
    case (i)
      3'd0: initial_hash = 32'h6a09e667;
      3'd1: initial_hash = 32'hbb67ae85;
      3'd2: initial_hash = 32'h3c6ef372;
      3'd3: initial_hash = 32'ha54ff53a;
      3'd4: initial_hash = 32'h510e527f;
      3'd5: initial_hash = 32'h9b05688c;
      3'd6: initial_hash = 32'h1f83d9ab;
      default: initial_hash = 32'h5be0cd19;
    endcase
  endfunction

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

@@ sv/sha256_stream_hasher.sv @@
// SHA-256 streaming hasher. Send one transfer per message byte with command 0;
// send command 1 to finish, after which eight digest words come out, index 0
// first, last_word set on the eighth. The block then starts a fresh message.
// An absorb byte is taken in the idle state; every 64th byte starts a
// compression (load, 64 rounds through one round unit, hash add) that
// takes no bytes. A finish writes the padding one byte a cycle, runs one
// or two compressions, then a digest word per cycle while out_ready is high.
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Top level: controller and datapath of the streaming SHA-256 hasher.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_stream_hasher import sha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        command,
  input  wire logic [7:0]  data_byte,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [31:0] digest_word,
  output      logic [2:0]  word_index,
  output      logic        last_word
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // The controller owns all handshakes; the datapath only follows commands.
  sha_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .out_valid(out_valid), .out_ready(out_ready),
    .out_idx(word_index), .cmd(cmd), .stat(stat)
  );

  sha_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .data_byte(data_byte),
    .stat(stat), .hash_out(digest_word)
  );

  assign last_word = (word_index == 3'd7);
endmodule
`default_nettype wire

@@ sv/sha_datapath.sv @@
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, byte counter, message schedule, round unit and hash state.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_datapath import sha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  input  wire logic [7:0]  data_byte,
  output      dp_stat_t    stat,
  output      logic [31:0] hash_out
);
  // The block buffer is held as sixteen big-endian words; each word is
  // read at a fixed place by the schedule shift line.
  logic [31:0] win [16];
  logic [31:0] hash [8];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [63:0] byte_count;
  logic [7:0]  wr_byte;
  logic [63:0] bits;
  logic [31:0] w, sg0, sg1, s0, s1, ch, maj, t1, t2;

  assign bits = {byte_count[60:0], 3'b000};

  always_comb begin
    case (cmd.buf_src)
      SRC_DATA: wr_byte = data_byte;
      SRC_PAD:  wr_byte = PAD_BYTE;
      SRC_ZERO: wr_byte = 8'h00;
      default:  wr_byte = bits[{~cmd.len_sel, 3'b000} +: 8];
    endcase
  end

  // Schedule: window index 0 is the word for the current round.
  assign sg0 = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
  assign sg1 = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
  assign w = win[0];
  assign s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
  assign ch = (e & f) ^ (~e & g);
  assign t1 = h + s1 + ch + ROUND_K[cmd.round_idx] + w;
  assign s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
  assign maj = (a & b) ^ (a & c) ^ (b & c);
  assign t2 = s0 + maj;

  always_ff @(posedge clk) begin
    if (cmd.buf_write) begin
      win[cmd.buf_addr[5:2]][{~cmd.buf_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end
    if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
      win[15] <= win[0] + sg0 + win[9] + sg1;
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end else if (cmd.comp_init) begin
      a <= hash[0]; b <= hash[1]; c <= hash[2]; d <= hash[3];
      e <= hash[4]; f <= hash[5]; g <= hash[6]; h <= hash[7];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.hash_reinit) begin
      for (int i = 0; i < 8; i++) hash[i] <= initial_hash(3'(i));
    end else if (cmd.hash_update) begin
      hash[0] <= hash[0] + a; hash[1] <= hash[1] + b;
      hash[2] <= hash[2] + c; hash[3] <= hash[3] + d;
      hash[4] <= hash[4] + e; hash[5] <= hash[5] + f;
      hash[6] <= hash[6] + g; hash[7] <= hash[7] + h;
    end
    if (rst || cmd.count_clear) begin
      byte_count <= '0;
    end else if (cmd.count_inc) begin
      byte_count <= byte_count + 64'd1;
    end
  end

  assign stat.byte_count = byte_count;
  assign hash_out = hash[cmd.out_sel];
endmodule
`default_nettype wire

@@ sv/sha_controller.sv @@
// ----------------------------------------------------------------------------
// sha_controller
// Sequences byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_controller import sha_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic       command,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [2:0] out_idx,
  output      dp_cmd_t    cmd,
  input  wire dp_stat_t   stat
);
  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_ROUND, S_UPDATE, S_PADZ, S_LEN, S_OUT
  } state_t;

  state_t state;
  logic [5:0] fill;
  logic [5:0] rnd;
  logic       finishing;  // compression belongs to a finish
  logic       final_blk;  // length already written into this block
  logic [2:0] lcnt;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_idx = lcnt;

  always_comb begin
    cmd = '0;
    cmd.buf_addr = fill;
    cmd.round_idx = rnd;
    cmd.len_sel = lcnt;
    cmd.out_sel = lcnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.buf_write = 1'b1;
          cmd.buf_src = (command == CMD_FINISH) ? SRC_PAD : SRC_DATA;
          cmd.count_inc = (command == CMD_ABSORB);
        end
      end
      S_INIT: cmd.comp_init = 1'b1;
      S_ROUND: cmd.round_en = 1'b1;
      S_UPDATE: cmd.hash_update = 1'b1;
      S_PADZ: begin
        cmd.buf_write = 1'b1;
        cmd.buf_src = SRC_ZERO;
      end
      S_LEN: begin
        cmd.buf_write = 1'b1;
        cmd.buf_src = SRC_LEN;
        cmd.buf_addr = {3'b111, lcnt};
      end
      S_OUT: begin
        if (out_ready && lcnt == 3'd7) begin
          cmd.hash_reinit = 1'b1;
          cmd.count_clear = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      rnd <= '0;
      finishing <= 1'b0;
      final_blk <= 1'b0;
      lcnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            fill <= fill + 6'd1;
            if (command == CMD_FINISH) begin
              finishing <= 1'b1;
              final_blk <= 1'b0;
              // A pad byte in the last slot completes the block at once.
              state <= (fill == 6'd63) ? S_INIT : S_PADZ;
            end else if (fill == 6'd63) begin
              finishing <= 1'b0;
              state <= S_INIT;
            end
          end
        end
        S_PADZ: begin
          // Zero up to the length field, or to block end if the pad
          // byte landed past it.
          if (fill == LENGTH_OFFSET && !final_blk) begin
            lcnt <= '0;
            state <= S_LEN;
          end else begin
            fill <= fill + 6'd1;
            if (fill == 6'd63) state <= S_INIT;
          end
        end
        S_LEN: begin
          lcnt <= lcnt + 3'd1;
          if (lcnt == 3'd7) begin
            final_blk <= 1'b1;
            fill <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          rnd <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (!finishing) begin
            state <= S_IDLE;
          end else if (final_blk) begin
            lcnt <= '0;
            state <= S_OUT;
          end else begin
            state <= S_PADZ;  // extra block: fill from zero
          end
        end
        S_OUT: begin
          if (out_ready) begin
            lcnt <= lcnt + 3'd1;
            if (lcnt == 3'd7) begin
              finishing <= 1'b0;
              fill <= '0;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic unused;
  assign unused = ^stat.byte_count[63:61];
endmodule
`default_nettype wire

@@ sv/sha_checker.sv @@
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks of the hasher's output sequence.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_stream_hasher_assert.svh"
module sha_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] word_index,
  input wire logic       last_word
);
  `SHA_ASSERT_IMP(a_last, clk, rst, out_valid, last_word == (word_index == 3'd7))
  `SHA_ASSERT_IMP(a_excl, clk, rst, out_valid, !in_ready)
  `SHA_ASSERT_NEXT(a_step, clk, rst, out_valid && out_ready && !last_word,
    out_valid && word_index == $past(word_index) + 3'd1)
  `SHA_ASSERT_NEXT(a_end, clk, rst, out_valid && out_ready && last_word, in_ready)
endmodule
bind sha256_stream_hasher sha_checker u_chk (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .word_index(word_index), .last_word(last_word)
);
`default_nettype wire
